### rtl/core/pkrld_pkg.sv
// ----------------------------------------------------------------------------
// PK glyph decoder package
// Types and constants shared by the number decoder, the row painter and the
// sequencer of the PK run-length glyph decoder.
// ----------------------------------------------------------------------------
package pkrld_pkg;

    localparam int ROW_W = 64;

    localparam logic [23:0] SAT24        = 24'hFFFFFF;
    localparam logic [3:0]  NYB_REPEAT   = 4'd14;
    localparam logic [3:0]  NYB_REPEAT_1 = 4'd15;
    localparam logic [3:0]  DYN_MAX      = 4'd13;
    localparam logic [3:0]  NYB_MASK     = 4'h0f;

    typedef enum logic [1:0]
    {
        NK_NONE,
        NK_RUN,
        NK_REPEAT,
        NK_FAIL
    } num_kind_t;

    typedef struct packed
    {
        num_kind_t   kind;
        logic [23:0] value;
    } num_evt_t;

    typedef struct packed
    {
        logic       clear;
        logic       seg;
        logic       black;
        logic [6:0] count;
    } paint_cmd_t;

endpackage

### rtl/core/pkrld_number.sv
// ----------------------------------------------------------------------------
// PK packed number decoder
// Takes one nybble per step and recognizes short, two-nybble and long packed
// numbers and repeat prefixes; reports a finished run or repeat count or a failure.
// ----------------------------------------------------------------------------
module pkrld_number
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                step,
    input  logic [3:0]          nybble,
    input  logic [3:0]          dyn,
    input  logic                repeat_seen,
    output pkrld_pkg::num_evt_t evt
);
    import pkrld_pkg::*;

    typedef enum logic [1:0]
    {
        M_FIRST,
        M_ZEROS,
        M_LONG,
        M_SECOND
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [3:0]  zeros_reg, zeros_next;
    logic [23:0] acc_reg, acc_next;
    logic        is_rep_reg, is_rep_next;

    logic        finish;
    logic [23:0] value;
    logic [23:0] long_acc;
    logic [3:0]  long_zeros;
    logic [7:0]  dyn_x15;
    logic [24:0] long_sum;
    logic [23:0] long_val;
    logic [3:0]  second_diff;
    logic [23:0] second_val;

    always_comb
    begin
        mode_next   = mode_reg;
        zeros_next  = zeros_reg;
        acc_next    = acc_reg;
        is_rep_next = is_rep_reg;
        evt.kind    = NK_NONE;
        evt.value   = '0;
        finish      = 1'b0;
        value       = '0;

        long_acc    = (acc_reg > (SAT24 >> 4)) ? SAT24 : {acc_reg[19:0], nybble};
        long_zeros  = (zeros_reg != 4'd0) ? zeros_reg - 4'd1 : zeros_reg;
        dyn_x15     = {dyn, 4'b0} - {4'b0, dyn};
        long_sum    = {1'b0, long_acc} + 25'd193 - {17'b0, dyn_x15};
        long_val    = long_sum[24] ? SAT24 : long_sum[23:0];
        second_diff = acc_reg[3:0] - dyn - 4'd1;
        second_val  = {16'b0, second_diff, 4'b0} + {20'b0, nybble} + {20'b0, dyn} + 24'd1;

        if (step)
        begin
            unique case (mode_reg)
                M_FIRST:
                begin
                    priority if (nybble == 4'd0)
                    begin
                        zeros_next = 4'd1;
                        mode_next  = M_ZEROS;
                    end
                    else if (nybble <= dyn)
                    begin
                        value  = {20'b0, nybble};
                        finish = 1'b1;
                    end
                    else if (nybble < NYB_REPEAT)
                    begin
                        acc_next  = {20'b0, nybble};
                        mode_next = M_SECOND;
                    end
                    else if (repeat_seen || is_rep_reg)
                    begin
                        evt.kind = NK_FAIL;
                    end
                    else if (nybble == NYB_REPEAT)
                    begin
                        is_rep_next = 1'b1;
                    end
                    else
                    begin
                        evt.kind  = NK_REPEAT;
                        evt.value = 24'd1;
                    end
                end
                M_ZEROS:
                begin
                    if (nybble == 4'd0)
                    begin
                        if (zeros_reg != NYB_MASK)
                        begin
                            zeros_next = zeros_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        acc_next  = {20'b0, nybble};
                        mode_next = M_LONG;
                    end
                end
                M_LONG:
                begin
                    acc_next   = long_acc;
                    zeros_next = long_zeros;
                    if (long_zeros == 4'd0)
                    begin
                        value  = long_val;
                        finish = 1'b1;
                    end
                end
                M_SECOND:
                begin
                    value  = second_val;
                    finish = 1'b1;
                end
            endcase

            if (finish)
            begin
                mode_next   = M_FIRST;
                is_rep_next = 1'b0;
                evt.kind    = is_rep_reg ? NK_REPEAT : NK_RUN;
                evt.value   = value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_FIRST;
            zeros_reg  <= '0;
            acc_reg    <= '0;
            is_rep_reg <= 1'b0;
        end
        else if (clear)
        begin
            mode_reg   <= M_FIRST;
            zeros_reg  <= '0;
            acc_reg    <= '0;
            is_rep_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            zeros_reg  <= zeros_next;
            acc_reg    <= acc_next;
            is_rep_reg <= is_rep_next;
        end
    end

endmodule

### rtl/core/pkrld_painter.sv
// ----------------------------------------------------------------------------
// PK row painter
// Holds the row being built and its column; one shared mask unit paints one
// run segment per command.
// ----------------------------------------------------------------------------
module pkrld_painter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pkrld_pkg::paint_cmd_t cmd,
    output logic [63:0]           row_bits,
    output logic [6:0]            column
);
    import pkrld_pkg::*;

    localparam logic [ROW_W-1:0] ALL_ONES = '1;

    logic [ROW_W-1:0] row_reg;
    logic [6:0]       col_reg;
    logic [7:0]       seg_end;
    logic [ROW_W-1:0] mask;

    always_comb
    begin
        seg_end = {1'b0, col_reg} + {1'b0, cmd.count};
        mask    = (ALL_ONES >> col_reg) & ~(ALL_ONES >> seg_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.clear)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.seg)
        begin
            if (cmd.black)
            begin
                row_reg <= row_reg | mask;
            end
            col_reg <= seg_end[6:0];
        end
    end

    assign row_bits = row_reg;
    assign column   = col_reg;

endmodule

### rtl/core/pk_run_length_glyph_decoder_core.sv
// ----------------------------------------------------------------------------
// PK run-length glyph decoder
// Decodes the packed run-length raster of one PK font glyph into pixel rows.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer
//  apb       in         register write or read in setup and access phases
//  s_axis    in         one packed byte, start_glyph flag in tuser
//  m_axis    out        one pixel row, row number, done and error flags, tlast
//
// A byte is taken, then each nybble is stepped, each run segment is painted or
// row boundary reached, each run is closed, each row or error result is
// emitted, and the last result is handed off. The input is ready only between
// bytes; the output register holds a result while the next byte is taken. Reset
// clears the decoder to a white first run. A stalled output stops row emission
// until the result is taken.
// ----------------------------------------------------------------------------
module pk_run_length_glyph_decoder_core
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] packed_byte
    input  logic [0:0]  s_tuser,   // [0] start_glyph
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] row_bits, [69:64] row_number, rest zero
    output logic [1:0]  m_tuser,   // [0] glyph_done, [1] bad_repeat
    output logic        m_tlast    // last_of_run
);
    import pkrld_pkg::*;

    localparam logic [1:0] REG_DYN_F  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_FIRST  = 2'd3;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_NYB,
        ST_PAINT,
        ST_EMIT,
        ST_FAIL,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0]
    {
        GS_RUN,
        GS_DONE,
        GS_ERR
    } glyph_status_t;

    logic [3:0] dyn_f_reg;
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    logic       first_black_reg;

    logic [3:0] dyn_eff;
    logic [6:0] w_eff;
    logic [6:0] h_eff;

    state_t        state_reg, state_next;
    glyph_status_t status_reg, status_next;
    logic [7:0]    byte_reg, byte_next;
    logic          low_sel_reg, low_sel_next;
    logic [6:0]    rows_done_reg, rows_done_next;
    logic [23:0]   run_left_reg, run_left_next;
    logic          colour_reg, colour_next;
    logic [6:0]    repeat_rows_reg, repeat_rows_next;
    logic          repeat_seen_reg, repeat_seen_next;
    logic [5:0]    rep_left_reg, rep_left_next;

    logic          pend_vld_reg, pend_vld_next;
    logic [63:0]   pend_bits_reg, pend_bits_next;
    logic [5:0]    pend_row_reg, pend_row_next;
    logic          pend_done_reg, pend_done_next;
    logic          pend_bad_reg, pend_bad_next;

    logic          m_vld_reg, m_vld_next;
    logic [63:0]   m_bits_reg, m_bits_next;
    logic [5:0]    m_row_reg, m_row_next;
    logic          m_done_reg, m_done_next;
    logic          m_bad_reg, m_bad_next;
    logic          m_last_reg, m_last_next;

    logic          num_clear;
    logic          num_step;
    logic [3:0]    nybble;
    num_evt_t      evt;
    paint_cmd_t    cmd;
    logic [63:0]   row_bits;
    logic [6:0]    column;

    logic          cfg_write;
    logic          can_push;
    logic          out_free;
    logic          adv;
    logic          emit;
    logic [63:0]   e_bits;
    logic [5:0]    e_row;
    logic          e_done;
    logic          e_bad;
    logic [6:0]    rows_plus1;
    logic [6:0]    rem;
    logic [6:0]    rep_clamped;
    logic [6:0]    space;
    logic [6:0]    seg_n;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DYN_F:  prdata = {28'b0, dyn_f_reg};
            REG_WIDTH:  prdata = {25'b0, width_reg};
            REG_HEIGHT: prdata = {25'b0, height_reg};
            REG_FIRST:  prdata = {31'b0, first_black_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dyn_f_reg       <= '0;
            width_reg       <= 7'd1;
            height_reg      <= 7'd1;
            first_black_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_DYN_F:  dyn_f_reg       <= pwdata[3:0];
                REG_WIDTH:  width_reg       <= pwdata[6:0];
                REG_HEIGHT: height_reg      <= pwdata[6:0];
                REG_FIRST:  first_black_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        dyn_eff = (dyn_f_reg > DYN_MAX) ? DYN_MAX : dyn_f_reg;

        if (width_reg == 7'd0)
            w_eff = 7'd1;
        else if (width_reg > 7'(MAX_WIDTH))
            w_eff = 7'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == 7'd0)
            h_eff = 7'd1;
        else if (height_reg > 7'(MAX_HEIGHT))
            h_eff = 7'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign nybble = low_sel_reg ? byte_reg[3:0] : byte_reg[7:4];

    pkrld_number u_number
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (num_clear),
        .step        (num_step),
        .nybble      (nybble),
        .dyn         (dyn_eff),
        .repeat_seen (repeat_seen_reg),
        .evt         (evt)
    );

    pkrld_painter u_painter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .row_bits (row_bits),
        .column   (column)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign can_push = !pend_vld_reg || !m_vld_reg || m_tready;
    assign out_free = !m_vld_reg || m_tready;

    always_comb
    begin
        rows_plus1  = rows_done_reg + 7'd1;
        rem         = (rows_plus1 >= h_eff) ? 7'd0 : h_eff - rows_plus1;
        rep_clamped = (repeat_rows_reg > rem) ? rem : repeat_rows_reg;
        space       = w_eff - column;
        seg_n       = (run_left_reg < {17'b0, space}) ? run_left_reg[6:0] : space;
    end

    always_comb
    begin
        state_next       = state_reg;
        status_next      = status_reg;
        byte_next        = byte_reg;
        low_sel_next     = low_sel_reg;
        rows_done_next   = rows_done_reg;
        run_left_next    = run_left_reg;
        colour_next      = colour_reg;
        repeat_rows_next = repeat_rows_reg;
        repeat_seen_next = repeat_seen_reg;
        rep_left_next    = rep_left_reg;
        pend_vld_next    = pend_vld_reg;
        pend_bits_next   = pend_bits_reg;
        pend_row_next    = pend_row_reg;
        pend_done_next   = pend_done_reg;
        pend_bad_next    = pend_bad_reg;
        m_vld_next       = m_vld_reg && !m_tready;
        m_bits_next      = m_bits_reg;
        m_row_next       = m_row_reg;
        m_done_next      = m_done_reg;
        m_bad_next       = m_bad_reg;
        m_last_next      = m_last_reg;
        num_clear        = 1'b0;
        num_step         = 1'b0;
        cmd              = '0;
        adv              = 1'b0;
        emit             = 1'b0;
        e_bits           = '0;
        e_row            = rows_done_reg[5:0];
        e_done           = 1'b0;
        e_bad            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next    = s_tdata;
                    low_sel_next = 1'b0;
                    state_next   = ST_NYB;
                    if (s_tuser[0])
                    begin
                        status_next      = GS_RUN;
                        rows_done_next   = '0;
                        run_left_next    = '0;
                        colour_next      = first_black_reg;
                        repeat_rows_next = '0;
                        repeat_seen_next = 1'b0;
                        num_clear        = 1'b1;
                        cmd.clear        = 1'b1;
                    end
                end
            end
            ST_NYB:
            begin
                if (status_reg != GS_RUN)
                begin
                    adv = 1'b1;
                end
                else if (rows_done_reg >= h_eff)
                begin
                    status_next = GS_DONE;
                    adv         = 1'b1;
                end
                else
                begin
                    num_step = 1'b1;
                    unique case (evt.kind)
                        NK_NONE:
                        begin
                            adv = 1'b1;
                        end
                        NK_REPEAT:
                        begin
                            repeat_rows_next = (|evt.value[23:7]) ? 7'd127 : evt.value[6:0];
                            repeat_seen_next = 1'b1;
                            adv              = 1'b1;
                        end
                        NK_FAIL:
                        begin
                            status_next   = GS_ERR;
                            run_left_next = '0;
                            state_next    = ST_FAIL;
                        end
                        NK_RUN:
                        begin
                            run_left_next = evt.value;
                            colour_next   = !colour_reg;
                            state_next    = ST_PAINT;
                        end
                    endcase
                end
            end
            ST_PAINT:
            begin
                if (status_reg != GS_RUN)
                begin
                    adv = 1'b1;
                end
                else if (column >= w_eff)
                begin
                    rep_left_next = rep_clamped[5:0];
                    state_next    = ST_EMIT;
                end
                else if (run_left_reg == 24'd0)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    cmd.seg       = 1'b1;
                    cmd.black     = !colour_reg;
                    cmd.count     = seg_n;
                    run_left_next = run_left_reg - {17'b0, seg_n};
                end
            end
            ST_EMIT:
            begin
                if (can_push)
                begin
                    emit           = 1'b1;
                    e_bits         = row_bits;
                    e_done         = (rows_plus1 >= h_eff);
                    rows_done_next = rows_plus1;
                    if (rep_left_reg == 6'd0)
                    begin
                        cmd.clear        = 1'b1;
                        repeat_rows_next = '0;
                        repeat_seen_next = 1'b0;
                        if (rows_plus1 >= h_eff)
                        begin
                            status_next   = GS_DONE;
                            run_left_next = '0;
                        end
                        state_next = ST_PAINT;
                    end
                    else
                    begin
                        rep_left_next = rep_left_reg - 6'd1;
                    end
                end
            end
            ST_FAIL:
            begin
                if (can_push)
                begin
                    emit  = 1'b1;
                    e_bad = 1'b1;
                    adv   = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    m_vld_next    = 1'b1;
                    m_bits_next   = pend_bits_reg;
                    m_row_next    = pend_row_reg;
                    m_done_next   = pend_done_reg;
                    m_bad_next    = pend_bad_reg;
                    m_last_next   = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            if (!low_sel_reg)
            begin
                low_sel_next = 1'b1;
                state_next   = ST_NYB;
            end
            else
            begin
                state_next = ST_FLUSH;
            end
        end

        if (emit)
        begin
            if (pend_vld_reg)
            begin
                m_vld_next  = 1'b1;
                m_bits_next = pend_bits_reg;
                m_row_next  = pend_row_reg;
                m_done_next = pend_done_reg;
                m_bad_next  = pend_bad_reg;
                m_last_next = 1'b0;
            end
            pend_vld_next  = 1'b1;
            pend_bits_next = e_bits;
            pend_row_next  = e_row;
            pend_done_next = e_done;
            pend_bad_next  = e_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            status_reg      <= GS_RUN;
            byte_reg        <= '0;
            low_sel_reg     <= 1'b0;
            rows_done_reg   <= '0;
            run_left_reg    <= '0;
            colour_reg      <= 1'b0;
            repeat_rows_reg <= '0;
            repeat_seen_reg <= 1'b0;
            rep_left_reg    <= '0;
            pend_vld_reg    <= 1'b0;
            pend_bits_reg   <= '0;
            pend_row_reg    <= '0;
            pend_done_reg   <= 1'b0;
            pend_bad_reg    <= 1'b0;
            m_vld_reg       <= 1'b0;
            m_bits_reg      <= '0;
            m_row_reg       <= '0;
            m_done_reg      <= 1'b0;
            m_bad_reg       <= 1'b0;
            m_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            status_reg      <= status_next;
            byte_reg        <= byte_next;
            low_sel_reg     <= low_sel_next;
            rows_done_reg   <= rows_done_next;
            run_left_reg    <= run_left_next;
            colour_reg      <= colour_next;
            repeat_rows_reg <= repeat_rows_next;
            repeat_seen_reg <= repeat_seen_next;
            rep_left_reg    <= rep_left_next;
            pend_vld_reg    <= pend_vld_next;
            pend_bits_reg   <= pend_bits_next;
            pend_row_reg    <= pend_row_next;
            pend_done_reg   <= pend_done_next;
            pend_bad_reg    <= pend_bad_next;
            m_vld_reg       <= m_vld_next;
            m_bits_reg      <= m_bits_next;
            m_row_reg       <= m_row_next;
            m_done_reg      <= m_done_next;
            m_bad_reg       <= m_bad_next;
            m_last_reg      <= m_last_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {2'b0, m_row_reg, m_bits_reg};
    assign m_tuser  = {m_bad_reg, m_done_reg};
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_vld_reg)
        else $error("input ready while a result is still held back");

    a_bad_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[63:0] == 64'd0) && !m_tuser[0])
        else $error("error result carries pixels or a done flag");

    a_bad_stops_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg && pend_bad_reg |-> status_reg == GS_ERR)
        else $error("error result pending while the glyph still runs");

    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        column <= 7'(MAX_WIDTH))
        else $error("column beyond the widest row");

    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_done_reg <= 7'(MAX_HEIGHT))
        else $error("row count beyond the tallest glyph");
`endif

endmodule
